@@ rtl/teq_pkg.sv @@
// Shared types and constants for the timed event queue.
`timescale 1ns / 1ps
`default_nettype none
package teq_pkg;

  localparam int DUE_W           = 32;
  localparam int TAG_W           = 8;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_BITS_DEF    = 8;

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_ATTACH = 1'b1
  } teq_op_t;

  typedef enum logic {
    ST_FIRED  = 1'b0,
    ST_REJECT = 1'b1
  } teq_status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_TICK = 1'b1
  } teq_state_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic             insert;
    logic             pop;
    logic [DUE_W-1:0] new_due;
    logic [DUE_W-1:0] frame;
  } teq_cmd_t;

endpackage
`default_nettype wire

@@ rtl/teq_if.sv @@
// Request and result channel interfaces of the timed event queue.
`timescale 1ns / 1ps
`default_nettype none
interface teq_req_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [teq_pkg::DUE_W-1:0] due_frame;
  logic [teq_pkg::TAG_W-1:0] event_tag;

  modport source (output valid, output operation, output due_frame, output event_tag,
                  input ready);
  modport sink   (input valid, input operation, input due_frame, input event_tag,
                  output ready);
endinterface

interface teq_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [teq_pkg::TAG_W-1:0] fired_tag;
  logic                      status;
  logic                      last_of_run;

  modport source (output valid, output fired_tag, output status, output last_of_run,
                  input ready);
  modport sink   (input valid, input fired_tag, input status, input last_of_run,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/teq_cell.sv @@
// One slot of the sorted chain: holds a due frame and tag, shifts right on insert, left on pop.
`timescale 1ns / 1ps
`default_nettype none
module teq_cell #(
  parameter int TAG_BITS = teq_pkg::TAG_BITS_DEF
) (
  input  wire  logic                      clk,
  input  wire  teq_pkg::teq_cmd_t         cmd,
  input  wire  logic                      occupied,
  input  wire  logic [TAG_BITS-1:0]       new_tag,
  input  wire  logic                      left_ge,
  input  wire  logic [teq_pkg::DUE_W-1:0] left_due,
  input  wire  logic [TAG_BITS-1:0]       left_tag,
  input  wire  logic [teq_pkg::DUE_W-1:0] right_due,
  input  wire  logic [TAG_BITS-1:0]       right_tag,
  output logic [teq_pkg::DUE_W-1:0]       due,
  output logic [TAG_BITS-1:0]             tag,
  output logic                            ge_new,
  output logic                            le_frame
);

  assign ge_new   = occupied && (due >= cmd.new_due);
  assign le_frame = occupied && (due <= cmd.frame);

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (left_ge) begin
        due <= left_due;
        tag <= left_tag;
      end else if (ge_new || !occupied) begin
        due <= cmd.new_due;
        tag <= new_tag;
      end
    end else if (cmd.pop) begin
      due <= right_due;
      tag <= right_tag;
    end
  end

endmodule
`default_nettype wire

@@ rtl/timed_event_queue.sv @@
// Top level: sorted event queue built from a chain of cells, with tick release control.
//
//   channel   role    payload                              moves per transfer
//   request   sink    operation, due_frame, event_tag      one tick or one attach
//   result    source  fired_tag, status, last_of_run       one fired or rejected event
//
// Attach: every cell compares against the new due frame in parallel; cells from the insertion point on shift right.
// Tick: one head pop per cycle while the result register is free, each pop shifting the chain left.
// Reset (rst, synchronous) empties the queue and clears the frame counter.
// A stalled result register holds the controller; new requests wait until it drains.
`timescale 1ns / 1ps
`default_nettype none
module timed_event_queue #(
  parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = teq_pkg::TAG_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  teq_req_if.sink   request,
  teq_rsp_if.source result
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int DW    = teq_pkg::DUE_W;
  localparam int TW    = teq_pkg::TAG_W;

  teq_pkg::teq_state_t  state, state_next;
  teq_pkg::teq_cmd_t    cmd;
  teq_pkg::teq_status_t out_status;

  logic [CNT_W-1:0]    entry_count, entry_count_next;
  logic [DW-1:0]       frame_counter;
  logic [DW-1:0]       due_q [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] tag_q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] ge_new, le_frame, occupied;

  logic                out_valid;
  logic [TW-1:0]       out_tag;
  logic                out_last;
  logic                out_free;
  logic                full;
  logic                accept;
  logic [TAG_BITS-1:0] tag_in;
  logic [TW-1:0]       rej_tag8, head_tag8;

  logic do_insert, do_pop, load_reject, load_fire, advance;

  // tag width adaptation
  if (TAG_BITS <= TW) begin : g_tag_narrow
    assign tag_in    = request.event_tag[TAG_BITS-1:0];
    assign rej_tag8  = TW'(tag_in);
    assign head_tag8 = TW'(tag_q[0]);
  end else begin : g_tag_wide
    assign tag_in    = TAG_BITS'(request.event_tag);
    assign rej_tag8  = tag_in[TW-1:0];
    assign head_tag8 = tag_q[0][TW-1:0];
  end

  assign out_free = !out_valid || result.ready;
  assign full     = (entry_count == CNT_W'(QUEUE_DEPTH));
  assign accept   = request.valid && request.ready;

  assign cmd.insert  = do_insert;
  assign cmd.pop     = do_pop;
  assign cmd.new_due = request.due_frame;
  assign cmd.frame   = frame_counter;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [DW-1:0]       ld, rd;
    logic [TAG_BITS-1:0] lt, rt;
    logic                lge;

    assign occupied[i] = (CNT_W'(i) < entry_count);

    if (i == 0) begin : g_first
      assign ld  = '0;
      assign lt  = '0;
      assign lge = 1'b0;
    end else begin : g_left
      assign ld  = due_q[i-1];
      assign lt  = tag_q[i-1];
      assign lge = ge_new[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_end
      assign rd = due_q[i];
      assign rt = tag_q[i];
    end else begin : g_right
      assign rd = due_q[i+1];
      assign rt = tag_q[i+1];
    end

    teq_cell #(
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occupied  (occupied[i]),
      .new_tag   (tag_in),
      .left_ge   (lge),
      .left_due  (ld),
      .left_tag  (lt),
      .right_due (rd),
      .right_tag (rt),
      .due       (due_q[i]),
      .tag       (tag_q[i]),
      .ge_new    (ge_new[i]),
      .le_frame  (le_frame[i])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      teq_pkg::S_IDLE: begin
        if (accept && (request.operation == teq_pkg::OP_TICK)) begin
          state_next = teq_pkg::S_TICK;
        end
      end
      teq_pkg::S_TICK: begin
        if (advance) begin
          state_next = teq_pkg::S_IDLE;
        end
      end
      default: state_next = teq_pkg::S_IDLE;
    endcase
  end

  // controls
  always_comb begin
    request.ready = 1'b0;
    do_insert     = 1'b0;
    do_pop        = 1'b0;
    load_reject   = 1'b0;
    load_fire     = 1'b0;
    advance       = 1'b0;
    case (state)
      teq_pkg::S_IDLE: begin
        request.ready = out_free;
        if (request.valid && out_free && (request.operation == teq_pkg::OP_ATTACH)) begin
          if (full) begin
            load_reject = 1'b1;
          end else begin
            do_insert = 1'b1;
          end
        end
      end
      teq_pkg::S_TICK: begin
        if (out_free) begin
          if (le_frame[0]) begin
            do_pop    = 1'b1;
            load_fire = 1'b1;
            advance   = !le_frame[1];
          end else begin
            advance = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    entry_count_next = entry_count;
    if (do_insert) begin
      entry_count_next = entry_count + CNT_W'(1);
    end else if (do_pop) begin
      entry_count_next = entry_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= teq_pkg::S_IDLE;
      entry_count   <= '0;
      frame_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      if (advance) begin
        frame_counter <= frame_counter + DW'(1);
      end
      if (load_reject || load_fire) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_reject) begin
      out_tag    <= rej_tag8;
      out_status <= teq_pkg::ST_REJECT;
      out_last   <= 1'b1;
    end else if (load_fire) begin
      out_tag    <= head_tag8;
      out_status <= teq_pkg::ST_FIRED;
      out_last   <= !le_frame[1];
    end
  end

  assign result.valid       = out_valid;
  assign result.fired_tag   = out_tag;
  assign result.status      = out_status;
  assign result.last_of_run = out_last;

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_no_insert_full : assert property (@(posedge clk) disable iff (rst)
    do_insert |-> !full)
    else $error("insert into a full queue");

  a_head_sorted : assert property (@(posedge clk) disable iff (rst)
    (entry_count >= CNT_W'(2)) |-> (due_q[0] <= due_q[1]))
    else $error("head entries out of order");

  a_pop_due : assert property (@(posedge clk) disable iff (rst)
    do_pop |-> (entry_count != '0) && (due_q[0] <= frame_counter))
    else $error("pop of an entry that is not due");

  a_frame_step : assert property (@(posedge clk) disable iff (rst)
    advance |=> (state == teq_pkg::S_IDLE))
    else $error("tick did not finish after frame advance");

endmodule
`default_nettype wire
